/* hw/rtl/fvn_pkg.sv */
// Shared constants and default parameters for the fractal value noise core.
// Used by all modules under hw/rtl; no dependencies.
package fvn_pkg;

  localparam int CELL_SHIFT_DEF   = 6;
  localparam int OCTAVE_COUNT_DEF = 3;
  localparam int COORD_BITS_DEF   = 16;

  localparam int IN_BITS    = 16;
  localparam int NOISE_BITS = 31;
  localparam int HASH_BITS  = 32;

  localparam logic [HASH_BITS-1:0] HASH_ROW_MUL = 32'd57;
  localparam int                   HASH_XSHIFT  = 13;
  localparam logic [HASH_BITS-1:0] HASH_MUL_A   = 32'd15731;
  localparam logic [HASH_BITS-1:0] HASH_ADD_A   = 32'd789221;
  localparam logic [HASH_BITS-1:0] HASH_ADD_B   = 32'd1376312589;

  // Cycles from hash input to lattice value.
  localparam int HASH_LAT = 4;

endpackage

/* hw/rtl/fractal_value_noise_2d_core.sv */
// Stages: input reg, 4 hash stages, 2 blend stages, sum/output reg.
// Throughput: one word per cycle while the output word is not stalled.
// The whole pipeline holds while the output word is stalled.
// Reset (rst_n, synchronous) clears valid bits only; no clearing pass.
module fractal_value_noise_2d_core #(
  parameter int CELL_SHIFT   = fvn_pkg::CELL_SHIFT_DEF,
  parameter int OCTAVE_COUNT = fvn_pkg::OCTAVE_COUNT_DEF,
  parameter int COORD_BITS   = fvn_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fvn_pkg::IN_BITS-1:0]    in_x_coord,
  input  logic signed [fvn_pkg::IN_BITS-1:0]    in_y_coord,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fvn_pkg::NOISE_BITS-1:0] out_noise_value
);
  localparam int OW   = fvn_pkg::NOISE_BITS + 2 * CELL_SHIFT + 1;
  localparam int TW   = OW + OCTAVE_COUNT;
  localparam int DROP = 2 * CELL_SHIFT + OCTAVE_COUNT;
  localparam int VLEN = fvn_pkg::HASH_LAT + 3;

  logic en;
  logic [VLEN-1:0] vld_r;
  logic out_valid_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [31:0] x32, y32;
  logic signed [OW-1:0] oct [OCTAVE_COUNT];
  logic signed [TW-1:0] total;
  logic [fvn_pkg::NOISE_BITS-1:0] noise_nxt, noise_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign x32 = 32'($signed(in_x_coord));
  assign y32 = 32'($signed(in_y_coord));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLEN-2:0], in_valid};
      out_valid_r <= vld_r[VLEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= x32[COORD_BITS-1:0];
      y_r     <= y32[COORD_BITS-1:0];
      noise_r <= noise_nxt;
    end
  end

  for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
    fvn_octave #(
      .CELL_SHIFT(CELL_SHIFT), .COORD_BITS(COORD_BITS), .OCT_IDX(k)
    ) u_oct (
      .clk, .en, .x(x_r), .y(y_r), .oct(oct[k])
    );
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < OCTAVE_COUNT; k++)
      total = total + (TW'(oct[k]) <<< (OCTAVE_COUNT - 1 - k));
    noise_nxt = fvn_pkg::NOISE_BITS'(total >>> DROP);
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = $signed(noise_r);
endmodule

/* hw/rtl/fvn_hash.sv */
// Four-stage integer lattice hash, one corner per cycle while en is high.
// Depends on fvn_pkg.
module fvn_hash (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic        [fvn_pkg::HASH_BITS-1:0]  cx,
  input  logic        [fvn_pkg::HASH_BITS-1:0]  cy,
  output logic signed [fvn_pkg::NOISE_BITS-1:0] val
);
  logic [fvn_pkg::HASH_BITS-1:0] n0;
  logic [fvn_pkg::HASH_BITS-1:0] n_a_r, n_b_r, n_c_r, sq_b_r, t_c_r, h;
  logic [fvn_pkg::NOISE_BITS-1:0] val_r;

  assign n0 = cx + cy * fvn_pkg::HASH_ROW_MUL;
  assign h  = n_c_r * t_c_r + fvn_pkg::HASH_ADD_B;

  always_ff @(posedge clk) begin
    if (en) begin
      n_a_r  <= (n0 << fvn_pkg::HASH_XSHIFT) ^ n0;
      sq_b_r <= n_a_r * n_a_r;
      n_b_r  <= n_a_r;
      t_c_r  <= sq_b_r * fvn_pkg::HASH_MUL_A + fvn_pkg::HASH_ADD_A;
      n_c_r  <= n_b_r;
      // h - 2^30 on 31 bits is bit 30 flipped
      val_r  <= {~h[30], h[29:0]};
    end
  end

  assign val = $signed(val_r);
endmodule

/* hw/rtl/fvn_octave.sv */
// One octave: lattice split, four corner hashes, bilinear blend.
// Depends on fvn_pkg and fvn_hash.
module fvn_octave #(
  parameter int CELL_SHIFT = fvn_pkg::CELL_SHIFT_DEF,
  parameter int COORD_BITS = fvn_pkg::COORD_BITS_DEF,
  parameter int OCT_IDX    = 0,
  localparam int OW        = fvn_pkg::NOISE_BITS + 2 * CELL_SHIFT + 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  output logic signed [OW-1:0]  oct
);
  localparam int LW = fvn_pkg::NOISE_BITS + CELL_SHIFT + 1;
  localparam int HB = fvn_pkg::HASH_BITS;
  localparam int FDL = fvn_pkg::HASH_LAT;
  localparam logic [CELL_SHIFT:0] W = (CELL_SHIFT+1)'(1) << CELL_SHIFT;

  logic [COORD_BITS-1:0] xs, ys;
  logic [HB-1:0] cx0, cx1, cy0, cy1;
  logic signed [fvn_pkg::NOISE_BITS-1:0] v00, v01, v10, v11;
  logic [CELL_SHIFT-1:0] fx_d_r [FDL+1];
  logic [CELL_SHIFT-1:0] fy_d_r [FDL];
  logic [CELL_SHIFT:0] wfy, wfx;
  logic signed [LW-1:0] left_nxt, right_nxt, left_r, right_r;
  logic signed [OW-1:0] oct_nxt, oct_r;

  assign xs = x << OCT_IDX;
  assign ys = y << OCT_IDX;

  assign cx0 = HB'($signed(xs[COORD_BITS-1:CELL_SHIFT]));
  assign cy0 = HB'($signed(ys[COORD_BITS-1:CELL_SHIFT]));
  assign cx1 = HB'($signed({xs[COORD_BITS-1], xs[COORD_BITS-1:CELL_SHIFT]})) + HB'(1);
  assign cy1 = HB'($signed({ys[COORD_BITS-1], ys[COORD_BITS-1:CELL_SHIFT]})) + HB'(1);

  fvn_hash u_h00 (.clk, .en, .cx(cx0), .cy(cy0), .val(v00));
  fvn_hash u_h01 (.clk, .en, .cx(cx0), .cy(cy1), .val(v01));
  fvn_hash u_h10 (.clk, .en, .cx(cx1), .cy(cy0), .val(v10));
  fvn_hash u_h11 (.clk, .en, .cx(cx1), .cy(cy1), .val(v11));

  // delay fractions to meet the hash results
  always_ff @(posedge clk) begin
    if (en) begin
      fx_d_r[0] <= xs[CELL_SHIFT-1:0];
      fy_d_r[0] <= ys[CELL_SHIFT-1:0];
      for (int i = 1; i < FDL + 1; i++) fx_d_r[i] <= fx_d_r[i-1];
      for (int i = 1; i < FDL; i++) fy_d_r[i] <= fy_d_r[i-1];
    end
  end

  assign wfy = W - {1'b0, fy_d_r[FDL-1]};
  assign wfx = W - {1'b0, fx_d_r[FDL]};

  always_comb begin
    left_nxt  = $signed({1'b0, wfy}) * v00 + $signed({2'b0, fy_d_r[FDL-1]}) * v01;
    right_nxt = $signed({1'b0, wfy}) * v10 + $signed({2'b0, fy_d_r[FDL-1]}) * v11;
    oct_nxt   = $signed({1'b0, wfx}) * left_r + $signed({2'b0, fx_d_r[FDL]}) * right_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      oct_r   <= oct_nxt;
    end
  end

  assign oct = oct_r;
endmodule

/* hw/rtl/fvn_checker.sv */
// Port-level checks for fractal_value_noise_2d_core, bound to the top level.
// Depends on fvn_pkg.
module fvn_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [fvn_pkg::IN_BITS-1:0]    in_x_coord,
  input logic signed [fvn_pkg::IN_BITS-1:0]    in_y_coord,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [fvn_pkg::NOISE_BITS-1:0] out_noise_value
);
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output word");

  a_hold_vld: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_noise_value))
    else $error("output word changed under stall");
endmodule

bind fractal_value_noise_2d_core fvn_checker u_fvn_checker (.*);

/* tb/fractal_value_noise_2d_core_tb.sv */
// Self-checking testbench for fractal_value_noise_2d_core: streams coordinate
// words in bursts and checks each noise word against a built-in predictor.
// Depends on fvn_pkg and the core RTL.
module fractal_value_noise_2d_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CSHIFT  = fvn_pkg::CELL_SHIFT_DEF;
  localparam int OCTAVES = fvn_pkg::OCTAVE_COUNT_DEF;
  localparam int DROP    = 2 * CSHIFT + OCTAVES;
  localparam int N_RAND  = 1000;
  localparam int DRAIN   = 20;

  typedef struct packed {
    logic signed [fvn_pkg::IN_BITS-1:0] x;
    logic signed [fvn_pkg::IN_BITS-1:0] y;
  } coord_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic signed [fvn_pkg::IN_BITS-1:0]    in_x_coord = '0;
  logic signed [fvn_pkg::IN_BITS-1:0]    in_y_coord = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [fvn_pkg::NOISE_BITS-1:0] out_noise_value;

  logic signed [fvn_pkg::NOISE_BITS-1:0] noise_q[$];
  int                                    err_count = 0;
  bit                                    stim_done = 1'b0;

  fractal_value_noise_2d_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_noise_value(out_noise_value)
  );

  always #1 clk = ~clk;

  function automatic longint corner_value(longint cx, longint cy);
    logic [31:0] n;
    logic [31:0] h;
    n = cx[31:0] + cy[31:0] * fvn_pkg::HASH_ROW_MUL;
    n = (n << fvn_pkg::HASH_XSHIFT) ^ n;
    h = n * (n * n * fvn_pkg::HASH_MUL_A + fvn_pkg::HASH_ADD_A) + fvn_pkg::HASH_ADD_B;
    h[31] = 1'b0;
    return longint'({32'd0, h}) - (longint'(1) << 30);
  endfunction

  function automatic longint octave_blend(logic signed [fvn_pkg::IN_BITS-1:0] x,
                                          logic signed [fvn_pkg::IN_BITS-1:0] y);
    longint w, fx, fy, cx, cy, lft, rgt;
    w  = longint'(1) << CSHIFT;
    fx = longint'(x[CSHIFT-1:0]);
    fy = longint'(y[CSHIFT-1:0]);
    cx = longint'(x >>> CSHIFT);
    cy = longint'(y >>> CSHIFT);
    lft = (w - fy) * corner_value(cx, cy) + fy * corner_value(cx, cy + 1);
    rgt = (w - fy) * corner_value(cx + 1, cy) + fy * corner_value(cx + 1, cy + 1);
    return (w - fx) * lft + fx * rgt;
  endfunction

  function automatic logic signed [fvn_pkg::NOISE_BITS-1:0] fractal_noise(coord_t c);
    logic signed [fvn_pkg::IN_BITS-1:0] x, y;
    longint total;
    x = c.x;
    y = c.y;
    total = 0;
    for (int k = 0; k < OCTAVES; k++) begin
      total += octave_blend(x, y) * (longint'(1) << (OCTAVES - 1 - k));
      x = x <<< 1;
      y = y <<< 1;
    end
    total = total >>> DROP;
    return total[fvn_pkg::NOISE_BITS-1:0];
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    err_count++;
  endtask

  // Predict on every accepted coordinate word.
  always @(posedge clk) begin
    coord_t c;
    if (rst_n && in_valid && !in_stall) begin
      c.x = in_x_coord;
      c.y = in_y_coord;
      noise_q.push_back(fractal_noise(c));
    end
  end

  // Compare every accepted noise word with the oldest prediction.
  always @(posedge clk) begin
    logic signed [fvn_pkg::NOISE_BITS-1:0] exp_n;
    if (rst_n && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        report_mismatch("unexpected word", 0, out_noise_value);
      end else begin
        exp_n = noise_q.pop_front();
        if (out_noise_value !== exp_n) begin
          report_mismatch("noise_value", exp_n, out_noise_value);
        end
      end
    end
  end

  // Receiver stall pattern: alternate free stretches, random and heavy stalling.
  always @(posedge clk) begin
    static int mode = 0;
    static int left = 0;
    if (left == 0) begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(5, 60);
    end
    left--;
    case (mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  coord_t directed_tbl[] = '{
    '{16'sh0000, 16'sh0000}, '{16'sh7fff, 16'sh7fff}, '{-16'sd32768, -16'sd32768},
    '{16'sh7fff, -16'sd32768}, '{-16'sd32768, 16'sh7fff}, '{-16'sd1, -16'sd1},
    '{16'sd1, -16'sd1}, '{16'sd63, 16'sd63}, '{16'sd64, 16'sd64},
    '{-16'sd64, -16'sd64}, '{-16'sd65, 16'sd65}, '{16'sd32, 16'sd32},
    '{16'sh4000, 16'shc000}, '{16'sh3fff, 16'sh4001}, '{16'sd127, -16'sd128},
    '{16'sh5555, 16'shaaaa}, '{16'shaaaa, 16'sh5555}, '{16'sd1, 16'sd0},
    '{16'sd0, 16'sd1}, '{16'sh7fc0, 16'sh803f}
  };

  task automatic send_word(coord_t c);
    in_valid   <= 1'b1;
    in_x_coord <= c.x;
    in_y_coord <= c.y;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic maybe_gap();
    static int burst = 0;
    if (burst == 0) begin
      burst = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst--;
  endtask

  function automatic coord_t random_coord();
    coord_t c;
    case ($urandom_range(0, 3))
      0: begin
        c.x = $signed(16'($urandom_range(0, 255)) - 16'd128);
        c.y = $signed(16'($urandom_range(0, 255)) - 16'd128);
      end
      1: begin
        c.x = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 14'($urandom)};
        c.y = {$urandom_range(0, 1) ? 2'b11 : 2'b00, 14'($urandom)};
      end
      default: begin
        c.x = 16'($urandom);
        c.y = 16'($urandom);
      end
    endcase
    return c;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_tbl[i]) begin
      maybe_gap();
      send_word(directed_tbl[i]);
    end
    for (int i = 0; i < N_RAND; i++) begin
      maybe_gap();
      send_word(random_coord());
    end
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("[fractal_value_noise_2d_core] OK");
    end else begin
      $display("[fractal_value_noise_2d_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[fractal_value_noise_2d_core] ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_hash.sv
hw/rtl/fvn_octave.sv
hw/rtl/fractal_value_noise_2d_core.sv
hw/rtl/fvn_checker.sv
tb/fractal_value_noise_2d_core_tb.sv
